[hw/rtl/sha1h_pkg.sv]
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types, constants and command/status structs of the SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int ROUND_W      = 7;
    localparam int POS_W        = 6;
    localparam int LEN_W        = 64;
    localparam int CNT_W        = LEN_W - 3;   // byte count; bit length = count * 8
    localparam int EMIT_W       = 3;

    localparam logic [EMIT_W-1:0] LAST_WORD = EMIT_W'(DIGEST_WORDS - 1);

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [WORD_W-1:0] K_0 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K_3 = 32'hca62c1d6;

    localparam logic [WORD_W-1:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_ABSORB,
        PH_PAD,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic               absorb;     // accepted absorb item
        logic               finish;     // accepted finish item
        logic               load_work;  // a..e <= chaining words
        logic               round;      // one compression round
        logic [ROUND_W-1:0] round_idx;
        logic               add_chain;  // fold a..e into chain, clear block
        logic               write_len;  // with add_chain: length into fresh block
        logic               shift_out;  // advance digest word
        logic               restart;    // back to initial state
    } cmd_t;

    typedef struct packed {
        logic pos_last;   // next byte fills the block
        logic pos_late;   // marker lands in byte 56 or later
        logic cnt_full;   // length cannot grow by another byte
    } sts_t;

endpackage

[hw/rtl/sha1h_datapath.sv]
// ----------------------------------------------------------------------------
// sha1h_datapath
// Block buffer, message schedule shift line, round unit, chaining words and
// length counter. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module sha1h_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sha1h_pkg::cmd_t                cmd,
    input  logic [7:0]                     data_byte,
    output sha1h_pkg::sts_t                sts,
    output logic [sha1h_pkg::WORD_W-1:0]   digest_word,
    output logic                           length_error
);
    import sha1h_pkg::*;

    logic [WORD_W-1:0] blk_reg   [BLOCK_WORDS];
    logic [WORD_W-1:0] blk_next  [BLOCK_WORDS];
    logic [WORD_W-1:0] h_reg     [DIGEST_WORDS];
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;

    logic [WORD_W-1:0] sched_x;
    logic [WORD_W-1:0] w_cur;
    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] k_val;
    logic [WORD_W-1:0] temp;
    logic [LEN_W-1:0]  len;
    logic [7:0]        byte_val;
    logic              byte_we;

    assign len      = {cnt_reg, 3'b000};
    assign byte_val = cmd.finish ? PAD_MARKER : data_byte;
    assign byte_we  = (cmd.absorb && !sts.cnt_full) || cmd.finish;

    assign sts.pos_last = (pos_reg == {POS_W{1'b1}});
    assign sts.pos_late = (pos_reg[POS_W-1:3] == 3'b111);
    assign sts.cnt_full = &cnt_reg;

    assign digest_word  = h_reg[0];
    assign length_error = ovf_reg;

    // shift line keeps W[r-16..r-1] in blk_reg[0..15] during rounds
    always_comb
    begin
        sched_x = blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0];
        w_cur   = (cmd.round_idx < ROUND_W'(BLOCK_WORDS)) ? blk_reg[0]
                                                          : {sched_x[30:0], sched_x[31]};
        priority if (cmd.round_idx < ROUND_W'(20))
        begin
            f_val = (b_reg & c_reg) ^ (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (cmd.round_idx < ROUND_W'(40))
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (cmd.round_idx < ROUND_W'(60))
        begin
            f_val = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
        temp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;
    end

    always_comb
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            blk_next[i] = blk_reg[i];
        end
        if (cmd.round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                blk_next[i] = blk_reg[i+1];
            end
            blk_next[BLOCK_WORDS-1] = w_cur;
        end
        else if (cmd.add_chain)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                blk_next[i] = '0;
            end
            if (cmd.write_len)
            begin
                blk_next[14] = len[63:32];
                blk_next[15] = len[31:0];
            end
        end
        else if (byte_we)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    if (pos_reg[5:2] == 4'(i) && pos_reg[1:0] == 2'(j))
                    begin
                        blk_next[i][8*(3-j) +: 8] = byte_val;
                    end
                end
            end
            // short final block: length fits behind the marker
            if (cmd.finish && !sts.pos_late)
            begin
                blk_next[14] = len[63:32];
                blk_next[15] = len[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                blk_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                blk_reg[i] <= blk_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
            pos_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (cmd.absorb)
            begin
                if (sts.cnt_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (cmd.add_chain)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (cmd.shift_out)
            begin
                for (int i = 0; i < DIGEST_WORDS - 1; i++)
                begin
                    h_reg[i] <= h_reg[i+1];
                end
            end
            if (cmd.restart)
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    h_reg[i] <= H_INIT[i];
                end
                pos_reg <= '0;
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    // working variables carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

endmodule

[hw/rtl/sha1h_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1h_ctrl
// Sequencer: item acceptance, round counting, padding phases and digest
// word emission.
// ----------------------------------------------------------------------------
module sha1h_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            func,
    input  logic            out_stall,
    input  sha1h_pkg::sts_t sts,
    output logic            in_stall,
    output logic            out_valid,
    output logic            word_last,
    output sha1h_pkg::cmd_t cmd
);
    import sha1h_pkg::*;

    ctrl_state_t         state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [EMIT_W-1:0]   emit_reg, emit_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign word_last = (emit_reg == LAST_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_ABSORB;
            round_reg <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        round_next    = round_reg;
        emit_next     = emit_reg;
        cmd           = '0;
        cmd.round_idx = round_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_ABSORB)
                    begin
                        cmd.absorb = 1'b1;
                        if (sts.pos_last && !sts.cnt_full)
                        begin
                            phase_next = PH_ABSORB;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        phase_next = sts.pos_late ? PH_PAD : PH_FINAL;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    round_next = round_reg + ROUND_W'(1);
                end
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                unique case (phase_reg)
                    PH_PAD:
                    begin
                        cmd.write_len = 1'b1;
                        phase_next    = PH_FINAL;
                        state_next    = ST_LOAD;
                    end
                    PH_FINAL:
                    begin
                        emit_next  = '0;
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (emit_reg == LAST_WORD)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.shift_out = 1'b1;
                        emit_next     = emit_reg + EMIT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/sha1_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 message hasher fed one byte per item; emits a five-word digest.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): func=0 absorbs data_byte, func=1 ends
// the message. Output channel (out_valid/out_stall): five digest words, most
// significant first, word_last on the fifth, length_error on all five if
// bytes were dropped past the 2^64-1 bit limit.
// One item is in work at a time; in_stall is high while it is.
// Absorb: the byte that fills a 64-byte block starts a compression (work
// load, 80 rounds at one round per cycle, chain update). Finish: one
// compression before the first digest word, two when the marker lands in
// byte 56 or later and the length needs its own block; then one word per
// cycle while out_stall is low.
// A stalled digest word stays on the port; no input is taken until the last
// word is accepted, after which the hasher is back at its initial value.
// Reset loads the initial chaining words and clears block, length and flag.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sha1h_pkg::WORD_W-1:0]  digest_word,
    output logic                          word_last,
    output logic                          length_error
);
    import sha1h_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sha1h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .word_last (word_last),
        .cmd       (cmd)
    );

    sha1h_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .sts          (sts),
        .digest_word  (digest_word),
        .length_error (length_error)
    );

    a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest pending");

    a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_chain |-> $past(cmd.round))
        else $error("chain update without preceding round");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && word_last) |=> (!out_valid && !in_stall))
        else $error("not idle after last digest word");

    a_round_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |-> !(cmd.absorb || cmd.finish))
        else $error("byte write during compression");

endmodule
